[rtl/olr_pkg.sv]
// ----------------------------------------------------------------------------
// olr_pkg
// Shared sizes, entry layout and helpers for the overwriting log ring.
// ----------------------------------------------------------------------------
package olr_pkg;

	// Ring geometry
	localparam int SLOT_COUNT    = 256;
	localparam int PAYLOAD_BYTES = 8;
	localparam int SLOT_W        = $clog2(SLOT_COUNT);
	localparam int CNT_W         = $clog2(SLOT_COUNT + 1);

	// Field widths of one entry
	localparam int SEQ_W  = 32;
	localparam int KIND_W = 8;
	localparam int LEN_W  = 4;
	localparam int PAY_W  = 64;
	localparam int FLAG_W = 2;

	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOT_COUNT - 1);
	localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(SLOT_COUNT);
	localparam logic [SLOT_W-1:0] SLOT_STEP  = SLOT_W'(1);
	localparam logic [CNT_W-1:0]  CNT_STEP   = CNT_W'(1);

	// Flag codes: bit0 valid, bit1 synced
	localparam logic [FLAG_W-1:0] FLAGS_WRITTEN = 2'b01;
	localparam logic [FLAG_W-1:0] FLAGS_SYNCED  = 2'b11;

	// Command codes carried by an item
	typedef enum logic [1:0] {
		CMD_WRITE       = 2'd0,
		CMD_READ_OLDEST = 2'd1,
		CMD_MARK_SYNCED = 2'd2,
		CMD_ERASE       = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [KIND_W-1:0] kind;
		logic [LEN_W-1:0]  length;
		logic [PAY_W-1:0]  payload;
	} entry_t;

	// Control from the ring controller to the slot store
	typedef struct packed {
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		entry_t            wr_entry;
		logic              flag_wr_en;
		logic [SLOT_W-1:0] flag_addr;
		logic [FLAG_W-1:0] flag_data;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
	} store_req_t;

	// Clamp a requested length to the payload capacity
	function automatic logic [LEN_W-1:0] clamp_length(input logic [7:0] len);
		return (len > 8'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : len[LEN_W-1:0];
	endfunction

	// Zero every payload byte at or beyond the stored length
	function automatic logic [PAY_W-1:0] clip_payload(input logic [PAY_W-1:0] data,
			input logic [LEN_W-1:0] len);
		logic [PAY_W-1:0] res;
		res = '0;
		for (int i = 0; i < PAY_W / 8; i++) begin
			if (LEN_W'(i) < len) begin
				res[i*8 +: 8] = data[i*8 +: 8];
			end
		end
		return res;
	endfunction

endpackage

[rtl/olr_store.sv]
// ----------------------------------------------------------------------------
// olr_store
// Slot storage: entry memory and flag memory, one write and one registered
// read each cycle.
// ----------------------------------------------------------------------------
module olr_store (
	input  logic                                clk,
	input  olr_pkg::store_req_t                 req,
	output olr_pkg::entry_t                     rd_entry,
	output logic [olr_pkg::FLAG_W-1:0]          rd_flags
);

	olr_pkg::entry_t                    entry_mem [olr_pkg::SLOT_COUNT];
	logic [olr_pkg::FLAG_W-1:0]         flag_mem  [olr_pkg::SLOT_COUNT];
	olr_pkg::entry_t                    rd_entry_q;
	logic [olr_pkg::FLAG_W-1:0]         rd_flags_q;

	// Write the head entry
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			entry_mem[req.wr_addr] <= req.wr_entry;
		end
	end

	// Write flags: fresh entry at the head or sync mark at the tail
	always_ff @(posedge clk) begin
		if (req.flag_wr_en) begin
			flag_mem[req.flag_addr] <= req.flag_data;
		end
	end

	// Read the tail slot, hold the data until the next read
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_entry_q <= entry_mem[req.rd_addr];
			rd_flags_q <= flag_mem[req.rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_flags = rd_flags_q;

endmodule

[rtl/overwriting_log_ring_with_sync_marks.sv]
// An accepted item's result is registered and shown in the next cycle.
// Throughput: one item per cycle while results are taken; the single result
// register and the registered read port of the slot memory set that figure.
// Reset clears pointers and counters and sets the sequence number to one.
// Slot memory is not cleared; no clearing pass, items are taken at once.
// ----------------------------------------------------------------------------
// overwriting_log_ring_with_sync_marks
// Circular log store that overwrites its oldest entry when full, with read
// of the oldest unsynced entry, sync marking and erase.
// ----------------------------------------------------------------------------
module overwriting_log_ring_with_sync_marks (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  entry_type,
	input  logic [7:0]  payload_length,
	input  logic [63:0] payload_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [31:0] out_sequence,
	output logic [7:0]  out_type,
	output logic [1:0]  out_flags,
	output logic [3:0]  out_length,
	output logic [63:0] out_payload,
	output logic [8:0]  unsynced_entries,
	output logic [31:0] total_count
);

	logic [olr_pkg::SLOT_W-1:0] head_q, head_d;
	logic [olr_pkg::SLOT_W-1:0] tail_q, tail_d;
	logic [olr_pkg::CNT_W-1:0]  pending_q, pending_d;
	logic [31:0]                written_q, written_d;
	logic [31:0]                seq_q, seq_d;
	logic [31:0]                wrap_q, wrap_d;

	logic                       valid_s1;
	logic                       empty_s1;
	logic                       read_ok_s1;
	logic                       empty_c;
	logic                       read_ok_c;
	logic                       accept;
	logic [olr_pkg::LEN_W-1:0]  len_c;
	olr_pkg::cmd_t              cmd_c;
	olr_pkg::store_req_t        req;
	olr_pkg::entry_t            rd_entry;
	logic [olr_pkg::FLAG_W-1:0] rd_flags;

	// Take a new item whenever the result register is free or being drained
	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;
	assign cmd_c    = olr_pkg::cmd_t'(command);
	assign len_c    = olr_pkg::clamp_length(payload_length);

	// Command decode and next state of the ring
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		pending_d = pending_q;
		written_d = written_q;
		seq_d     = seq_q;
		wrap_d    = wrap_q;
		empty_c   = 1'b0;
		read_ok_c = 1'b0;

		req            = '0;
		req.wr_addr    = head_q;
		req.wr_entry   = '{seq: seq_q, kind: entry_type, length: len_c,
			payload: olr_pkg::clip_payload(payload_data, len_c)};
		req.flag_addr  = head_q;
		req.flag_data  = olr_pkg::FLAGS_WRITTEN;
		req.rd_addr    = tail_q;

		if (accept) begin
			case (cmd_c)
				olr_pkg::CMD_WRITE: begin
					req.wr_en      = 1'b1;
					req.flag_wr_en = 1'b1;
					seq_d          = seq_q + 32'd1;
					written_d      = written_q + 32'd1;
					if (head_q == olr_pkg::LAST_SLOT) begin
						head_d = '0;
						wrap_d = wrap_q + 32'd1;
					end else begin
						head_d = head_q + olr_pkg::SLOT_STEP;
					end
					// Full ring: the oldest entry is overwritten, drop it
					if (pending_q == olr_pkg::FULL_COUNT) begin
						tail_d = (tail_q == olr_pkg::LAST_SLOT) ? '0
							: tail_q + olr_pkg::SLOT_STEP;
					end else begin
						pending_d = pending_q + olr_pkg::CNT_STEP;
					end
				end
				olr_pkg::CMD_READ_OLDEST: begin
					if (pending_q == '0) begin
						empty_c = 1'b1;
					end else begin
						req.rd_en = 1'b1;
						read_ok_c = 1'b1;
					end
				end
				olr_pkg::CMD_MARK_SYNCED: begin
					if (pending_q != '0) begin
						req.flag_wr_en = 1'b1;
						req.flag_addr  = tail_q;
						req.flag_data  = olr_pkg::FLAGS_SYNCED;
						tail_d         = (tail_q == olr_pkg::LAST_SLOT) ? '0
							: tail_q + olr_pkg::SLOT_STEP;
						pending_d      = pending_q - olr_pkg::CNT_STEP;
					end
				end
				olr_pkg::CMD_ERASE: begin
					head_d    = '0;
					tail_d    = '0;
					pending_d = '0;
					written_d = '0;
				end
				default: begin
					head_d = head_q;
				end
			endcase
		end
	end

	// Hold ring pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			pending_q <= '0;
			written_q <= '0;
			seq_q     <= 32'd1;
			wrap_q    <= '0;
		end else begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			pending_q <= pending_d;
			written_q <= written_d;
			seq_q     <= seq_d;
			wrap_q    <= wrap_d;
		end
	end

	// Result register: valid and result kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			empty_s1   <= 1'b0;
			read_ok_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1   <= 1'b1;
			empty_s1   <= empty_c;
			read_ok_s1 <= read_ok_c;
		end else if (out_ready) begin
			valid_s1   <= 1'b0;
		end
	end

	olr_store u_store (
		.clk      (clk),
		.req      (req),
		.rd_entry (rd_entry),
		.rd_flags (rd_flags)
	);

	// Drive the result; counters change only on accept, so they match the item
	assign out_valid        = valid_s1;
	assign status           = empty_s1;
	assign out_sequence     = read_ok_s1 ? rd_entry.seq     : '0;
	assign out_type         = read_ok_s1 ? rd_entry.kind    : '0;
	assign out_flags        = read_ok_s1 ? rd_flags         : '0;
	assign out_length       = read_ok_s1 ? rd_entry.length  : '0;
	assign out_payload      = read_ok_s1 ? rd_entry.payload : '0;
	assign unsynced_entries = 9'(pending_q);
	assign total_count      = written_q;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the overwriting log ring. A behavioural copy of
// the ring predicts the result of every accepted item; results are compared
// field by field in order. Directed items cover empty reads, length clamping
// and erase, then random phases fill past capacity, mix and drain the ring
// under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {
		PHASE_FILL,
		PHASE_MIXED,
		PHASE_DRAIN
	} phase_t;

	typedef enum int {
		RX_OPEN,
		RX_CHOPPY,
		RX_CHOKED
	} rx_mode_t;

	typedef struct packed {
		logic        status;
		logic [31:0] sequence_no;
		logic [7:0]  kind;
		logic [1:0]  flags;
		logic [3:0]  length;
		logic [63:0] payload;
		logic [8:0]  unsynced;
		logic [31:0] total;
	} ring_result_t;

	// Behavioural ring and queue of results still owed by the block
	class log_ring_scoreboard;
		logic [31:0] slot_seq [olr_pkg::SLOT_COUNT];
		logic [7:0]  slot_kind [olr_pkg::SLOT_COUNT];
		logic [1:0]  slot_flags [olr_pkg::SLOT_COUNT];
		logic [3:0]  slot_len [olr_pkg::SLOT_COUNT];
		logic [63:0] slot_pay [olr_pkg::SLOT_COUNT];
		int          head_idx;
		int          tail_idx;
		int          unsynced;
		logic [31:0] written;
		logic [31:0] next_seq;
		ring_result_t owed_results[$];
		int          errors;

		function new();
			head_idx = 0;
			tail_idx = 0;
			unsynced = 0;
			written  = '0;
			next_seq = 32'd1;
			errors   = 0;
		endfunction

		function int following(int idx);
			return (idx + 1 >= olr_pkg::SLOT_COUNT) ? 0 : idx + 1;
		endfunction

		// Apply one accepted item and queue the result it owes
		function void note_command(olr_pkg::cmd_t cmd, logic [7:0] kind, logic [7:0] req_len,
				logic [63:0] data);
			ring_result_t res;
			logic [3:0]   kept_len;
			logic [63:0]  keep_mask;
			res = '0;
			case (cmd)
				olr_pkg::CMD_WRITE: begin
					kept_len  = (req_len > 8'(olr_pkg::PAYLOAD_BYTES))
						? 4'(olr_pkg::PAYLOAD_BYTES) : req_len[3:0];
					keep_mask = (kept_len >= 4'd8) ? '1 : (64'd1 << (8 * kept_len)) - 64'd1;
					slot_seq[head_idx]   = next_seq;
					slot_kind[head_idx]  = kind;
					slot_flags[head_idx] = olr_pkg::FLAGS_WRITTEN;
					slot_len[head_idx]   = kept_len;
					slot_pay[head_idx]   = data & keep_mask;
					next_seq = next_seq + 32'd1;
					written  = written + 32'd1;
					unsynced++;
					head_idx = following(head_idx);
					// drop the oldest entry once it has been overwritten
					if (unsynced > olr_pkg::SLOT_COUNT) begin
						tail_idx = following(tail_idx);
						unsynced--;
					end
				end
				olr_pkg::CMD_READ_OLDEST: begin
					if (unsynced == 0) begin
						res.status = 1'b1;
					end else begin
						res.sequence_no = slot_seq[tail_idx];
						res.kind        = slot_kind[tail_idx];
						res.flags       = slot_flags[tail_idx];
						res.length      = slot_len[tail_idx];
						res.payload     = slot_pay[tail_idx];
					end
				end
				olr_pkg::CMD_MARK_SYNCED: begin
					if (unsynced != 0) begin
						slot_flags[tail_idx] = slot_flags[tail_idx] | olr_pkg::FLAGS_SYNCED;
						tail_idx = following(tail_idx);
						unsynced--;
					end
				end
				default: begin
					head_idx = 0;
					tail_idx = 0;
					unsynced = 0;
					written  = '0;
				end
			endcase
			res.unsynced = 9'(unsynced);
			res.total    = written;
			owed_results.push_back(res);
		endfunction

		// Compare one delivered result with the oldest one owed
		function void check_result(ring_result_t got);
			ring_result_t want;
			if (owed_results.size() == 0) begin
				$error("result with none outstanding: status %0h seq %0h", got.status,
					got.sequence_no);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0h, got %0h", want.status, got.status);
				errors++;
			end
			if (got.sequence_no !== want.sequence_no) begin
				$error("out_sequence: expected %0h, got %0h", want.sequence_no, got.sequence_no);
				errors++;
			end
			if (got.kind !== want.kind) begin
				$error("out_type: expected %0h, got %0h", want.kind, got.kind);
				errors++;
			end
			if (got.flags !== want.flags) begin
				$error("out_flags: expected %0h, got %0h", want.flags, got.flags);
				errors++;
			end
			if (got.length !== want.length) begin
				$error("out_length: expected %0h, got %0h", want.length, got.length);
				errors++;
			end
			if (got.payload !== want.payload) begin
				$error("out_payload: expected %0h, got %0h", want.payload, got.payload);
				errors++;
			end
			if (got.unsynced !== want.unsynced) begin
				$error("unsynced_entries: expected %0h, got %0h", want.unsynced, got.unsynced);
				errors++;
			end
			if (got.total !== want.total) begin
				$error("total_count: expected %0h, got %0h", want.total, got.total);
				errors++;
			end
		endfunction
	endclass

	logic        clk              = 1'b0;
	logic        arst_n           = 1'b0;
	logic        in_valid         = 1'b0;
	logic        in_ready;
	logic [1:0]  command          = olr_pkg::CMD_WRITE;
	logic [7:0]  entry_type       = '0;
	logic [7:0]  payload_length   = '0;
	logic [63:0] payload_data     = '0;
	logic        out_valid;
	logic        out_ready        = 1'b0;
	logic        status;
	logic [31:0] out_sequence;
	logic [7:0]  out_type;
	logic [1:0]  out_flags;
	logic [3:0]  out_length;
	logic [63:0] out_payload;
	logic [8:0]  unsynced_entries;
	logic [31:0] total_count;

	log_ring_scoreboard ring_sb = new();

	int burst_left = 0;
	int rx_left    = 0;
	rx_mode_t rx_mode = RX_OPEN;

	overwriting_log_ring_with_sync_marks dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.entry_type       (entry_type),
		.payload_length   (payload_length),
		.payload_data     (payload_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.out_sequence     (out_sequence),
		.out_type         (out_type),
		.out_flags        (out_flags),
		.out_length       (out_length),
		.out_payload      (out_payload),
		.unsynced_entries (unsynced_entries),
		.total_count      (total_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Stall the receiver in modes that are picked at random and changed when their hold runs out
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_left = $urandom_range(128, 16);
			case ($urandom_range(2))
				0: rx_mode = RX_OPEN;
				1: rx_mode = RX_CHOPPY;
				default: rx_mode = RX_CHOKED;
			endcase
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_CHOPPY: out_ready <= ($urandom_range(1) == 0);
			default:   out_ready <= ($urandom_range(3) == 0);
		endcase
	end

	// Check every delivered result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			ring_sb.check_result({status, out_sequence, out_type, out_flags, out_length,
				out_payload, unsynced_entries, total_count});
		end
	end

	// Offer one item, holding it until accepted; pause between bursts
	task automatic issue(input olr_pkg::cmd_t cmd, input logic [7:0] kind,
			input logic [7:0] req_len, input logic [63:0] data);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 60)
				: $urandom_range(24, 1);
			in_valid <= 1'b0;
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end
		burst_left--;
		in_valid       <= 1'b1;
		command        <= cmd;
		entry_type     <= kind;
		payload_length <= req_len;
		payload_data   <= data;
		do @(posedge clk); while (!in_ready);
		ring_sb.note_command(cmd, kind, req_len, data);
	endtask

	function automatic logic [7:0] pick_length();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70) return 8'($urandom_range(8));
		if (roll < 90) return 8'($urandom_range(15, 9));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [63:0] pick_data();
		int roll;
		roll = $urandom_range(19);
		if (roll == 0) return '1;
		if (roll == 1) return '0;
		return {$urandom, $urandom};
	endfunction

	task automatic issue_random(input olr_pkg::cmd_t cmd);
		issue(cmd, 8'($urandom_range(255)), pick_length(), pick_data());
	endtask

	initial begin
		int            sent;
		int            phase_left;
		int            roll;
		int            drain_wait;
		phase_t        phase;
		olr_pkg::cmd_t cmd;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty ring, clamping and zeroing of lengths, erase
		issue(olr_pkg::CMD_READ_OLDEST, 8'hff, 8'hff, '1);
		issue(olr_pkg::CMD_MARK_SYNCED, 8'h00, 8'h00, '0);
		issue(olr_pkg::CMD_WRITE, 8'h00, 8'd0, '1);
		issue(olr_pkg::CMD_WRITE, 8'hff, 8'd8, '1);
		issue(olr_pkg::CMD_WRITE, 8'ha5, 8'd255, 64'h0123_4567_89ab_cdef);
		issue(olr_pkg::CMD_WRITE, 8'h5a, 8'd9, 64'hfedc_ba98_7654_3210);
		issue(olr_pkg::CMD_WRITE, 8'h3c, 8'd3, '1);
		issue(olr_pkg::CMD_WRITE, 8'h01, 8'd1, '0);
		issue(olr_pkg::CMD_READ_OLDEST, 8'h00, 8'h00, '0);
		issue(olr_pkg::CMD_MARK_SYNCED, 8'h00, 8'h00, '0);
		issue(olr_pkg::CMD_READ_OLDEST, 8'h00, 8'h00, '0);
		repeat (5) issue(olr_pkg::CMD_MARK_SYNCED, 8'hff, 8'hff, '1);
		issue(olr_pkg::CMD_READ_OLDEST, 8'h00, 8'h00, '0);
		issue(olr_pkg::CMD_WRITE, 8'h7e, 8'd7, '1);
		issue(olr_pkg::CMD_ERASE, 8'h00, 8'h00, '0);
		issue(olr_pkg::CMD_READ_OLDEST, 8'h00, 8'h00, '0);
		issue(olr_pkg::CMD_WRITE, 8'h81, 8'd4, 64'h8000_0000_8000_0001);
		issue(olr_pkg::CMD_READ_OLDEST, 8'h00, 8'h00, '0);
		issue(olr_pkg::CMD_ERASE, 8'hff, 8'hff, '1);

		// Random phases; open with a fill that overruns the ring
		sent  = 0;
		phase = PHASE_FILL;
		while (sent < 1000) begin
			case (phase)
				PHASE_FILL:  phase_left = $urandom_range(320, 270);
				PHASE_MIXED: phase_left = $urandom_range(80, 30);
				default:     phase_left = $urandom_range(60, 20);
			endcase
			while (phase_left > 0 && sent < 1000) begin
				roll = $urandom_range(99);
				case (phase)
					PHASE_FILL: begin
						cmd = (roll < 95) ? olr_pkg::CMD_WRITE : olr_pkg::CMD_READ_OLDEST;
					end
					PHASE_MIXED: begin
						if (roll < 40)      cmd = olr_pkg::CMD_WRITE;
						else if (roll < 70) cmd = olr_pkg::CMD_READ_OLDEST;
						else if (roll < 95) cmd = olr_pkg::CMD_MARK_SYNCED;
						else                cmd = olr_pkg::CMD_ERASE;
					end
					default: begin
						if (roll < 60)      cmd = olr_pkg::CMD_MARK_SYNCED;
						else if (roll < 95) cmd = olr_pkg::CMD_READ_OLDEST;
						else                cmd = olr_pkg::CMD_WRITE;
					end
				endcase
				issue_random(cmd);
				sent++;
				phase_left--;
			end
			roll = $urandom_range(99);
			if (roll < 15)      phase = PHASE_FILL;
			else if (roll < 65) phase = PHASE_MIXED;
			else                phase = PHASE_DRAIN;
		end
		in_valid <= 1'b0;

		// Collect what is still owed, then watch for strays
		drain_wait = 0;
		while (ring_sb.owed_results.size() != 0 && drain_wait < 20000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (8) @(posedge clk);
		if (ring_sb.owed_results.size() != 0) begin
			$error("%0d results never delivered", ring_sb.owed_results.size());
			ring_sb.errors++;
		end

		if (ring_sb.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

[files.f]
rtl/olr_pkg.sv
rtl/olr_store.sv
rtl/overwriting_log_ring_with_sync_marks.sv
tb/tb_top.sv
